FILE: design/dmsr_pkg.sv
// package for the dual motor speed ramp and pwm block
// types, register indexes and fixed constants; no dependencies
package dmsr_pkg;

    localparam int SPEED_W    = 15;
    localparam int TARGET_W   = 16;
    localparam int STEP_W     = 14;
    localparam int PERIOD_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int MAG_W      = 14;
    localparam int BASE_W     = 17;
    localparam int PROD_A_W   = 27;
    localparam int PROD_B_W   = 28;
    localparam int PROD_W     = PROD_A_W + PROD_B_W;
    localparam int QUOT_W     = 10;
    localparam int WIDE_W     = 17;

    localparam logic [STEP_W-1:0]   FULL_SCALE  = 14'd10000;
    localparam logic [BASE_W-1:0]   DUTY_OFFSET = 17'd10000;
    // ceil(2^44 / 100000), exact floor division for products below 2^27
    localparam logic [PROD_B_W-1:0] RECIP       = 28'd175921861;
    localparam int                  RECIP_SHIFT = 44;

    localparam logic [STEP_W-1:0]   RST_SPEED_CAP  = 14'd10000;
    localparam logic [STEP_W-1:0]   RST_ACCEL_STEP = 14'd30;
    localparam logic [STEP_W-1:0]   RST_DECEL_STEP = 14'd10;
    localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD = 10'd799;

    typedef enum logic [1:0] {
        ACT_SET  = 2'd0,
        ACT_TICK = 2'd1,
        ACT_STOP = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_CAP  = 2'd0,
        CFG_ACCEL_STEP = 2'd1,
        CFG_DECEL_STEP = 2'd2,
        CFG_PWM_PERIOD = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAMP_L,
        S_RAMP_R,
        S_MUL_L,
        S_DIV_L,
        S_MUL_R,
        S_DIV_R,
        S_DONE
    } t_state;

endpackage

FILE: design/dual_motor_speed_ramp_pwm.sv
// top level: two-axis speed ramp with pwm duty generation
// depends on dmsr_pkg (types, register indexes, reciprocal constant)
//
//  channel | signals                                            | dir
//  --------+----------------------------------------------------+-----
//  input   | i_in_valid/o_in_ready, action, two targets         | in
//  result  | o_out_valid/i_out_ready, four duties, flags, speeds | out
//  config  | i_cfg_wr_en, i_cfg_index, i_cfg_wdata              | in
//
// set, stop and the unused action pass from the take straight to the hand-over.
// a tick goes through the take, one ramp step per axis, two passes per axis through
// the one 27x28 multiplier (period times speed term, then the reciprocal of 100000)
// and the hand-over; the multiplier and the ramp unit are shared between the axes.
// input is taken again as soon as the result sits in the output register.
// a result that is not taken holds the next finished item in S_DONE.
// reset is synchronous, active low; state, config and block registers go to defaults (payload registers are not reset).
module dual_motor_speed_ramp_pwm #(
    parameter int DUTY_WIDTH = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_action,
    input  logic signed [dmsr_pkg::TARGET_W-1:0]   i_left_target_in,
    input  logic signed [dmsr_pkg::TARGET_W-1:0]   i_right_target_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [DUTY_WIDTH-1:0]                  o_left_forward_duty,
    output logic [DUTY_WIDTH-1:0]                  o_left_reverse_duty,
    output logic [DUTY_WIDTH-1:0]                  o_right_forward_duty,
    output logic [DUTY_WIDTH-1:0]                  o_right_reverse_duty,
    output logic                                   o_bridge_enable,
    output logic                                   o_driving,
    output logic signed [dmsr_pkg::SPEED_W-1:0]    o_left_speed_out,
    output logic signed [dmsr_pkg::SPEED_W-1:0]    o_right_speed_out,
    input  logic                                   i_cfg_wr_en,
    input  logic [dmsr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dmsr_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    localparam logic [31:0] DUTY_MAX = (32'd1 << DUTY_WIDTH) - 32'd1;

    // config registers
    logic [dmsr_pkg::STEP_W-1:0]   r_speed_cap;
    logic [dmsr_pkg::STEP_W-1:0]   r_accel_step;
    logic [dmsr_pkg::STEP_W-1:0]   r_decel_step;
    logic [dmsr_pkg::PERIOD_W-1:0] r_pwm_period;

    // block state
    logic signed [dmsr_pkg::SPEED_W-1:0] r_left_target, r_right_target;
    logic signed [dmsr_pkg::SPEED_W-1:0] r_left_speed, r_right_speed;
    logic [DUTY_WIDTH-1:0] r_duty_lf, r_duty_lr, r_duty_rf, r_duty_rr;
    logic                  r_enable;
    logic [dmsr_pkg::PROD_A_W-1:0] r_prod;

    dmsr_pkg::t_state r_state, n_state;

    // output register
    logic r_out_valid;
    logic [DUTY_WIDTH-1:0] r_o_lf, r_o_lr, r_o_rf, r_o_rr;
    logic r_o_enable, r_o_driving;
    logic signed [dmsr_pkg::SPEED_W-1:0] r_o_lspd, r_o_rspd;

    // control decoded from state
    logic w_in_take, w_out_load, w_ramp_right, w_mul_right, w_mul_stage2;

    logic [dmsr_pkg::STEP_W-1:0]          w_cap;
    logic signed [dmsr_pkg::SPEED_W-1:0]  w_ramp_spd, w_ramp_tgt, w_ramp_new;
    logic signed [dmsr_pkg::SPEED_W-1:0]  w_mul_spd;
    logic [dmsr_pkg::MAG_W-1:0]           w_mag;
    logic [dmsr_pkg::BASE_W-1:0]          w_base;
    logic [dmsr_pkg::PROD_A_W-1:0]        w_op_a;
    logic [dmsr_pkg::PROD_B_W-1:0]        w_op_b;
    logic [dmsr_pkg::PROD_W-1:0]          w_prod;
    logic [dmsr_pkg::QUOT_W-1:0]          w_quot;
    logic [DUTY_WIDTH-1:0]                w_duty;
    logic                                 w_motion;
    logic signed [dmsr_pkg::SPEED_W-1:0]  w_set_left, w_set_right;

    function automatic logic signed [dmsr_pkg::SPEED_W-1:0] f_limit(
        input logic signed [dmsr_pkg::WIDE_W-1:0] v,
        input logic [dmsr_pkg::STEP_W-1:0]       cap
    );
        logic signed [dmsr_pkg::WIDE_W-1:0] c;
        logic signed [dmsr_pkg::WIDE_W-1:0] r;
        c = $signed({3'b000, cap});
        if (v < -c) begin
            r = -c;
        end else if (v > c) begin
            r = c;
        end else begin
            r = v;
        end
        return r[dmsr_pkg::SPEED_W-1:0];
    endfunction

    function automatic logic signed [dmsr_pkg::SPEED_W-1:0] f_ramp(
        input logic signed [dmsr_pkg::SPEED_W-1:0] spd,
        input logic signed [dmsr_pkg::SPEED_W-1:0] tgt,
        input logic [dmsr_pkg::STEP_W-1:0]         up,
        input logic [dmsr_pkg::STEP_W-1:0]         dn,
        input logic [dmsr_pkg::STEP_W-1:0]         cap
    );
        logic signed [dmsr_pkg::WIDE_W-1:0] s, t, u, d, st, v;
        s = dmsr_pkg::WIDE_W'(spd);
        t = dmsr_pkg::WIDE_W'(tgt);
        u = $signed({3'b000, up});
        d = $signed({3'b000, dn});
        st = '0;
        v = s;
        if (s == t) begin
            return spd;
        end else if (s > 0 && t < 0) begin
            v = (s <= d) ? '0 : s - d;
        end else if (s < 0 && t > 0) begin
            // reversal stops at zero first
            v = (-s <= d) ? '0 : s + d;
        end else if (t > s) begin
            st = (s >= 0) ? u : d;
            v  = (t - s <= st) ? t : s + st;
        end else begin
            st = (s <= 0) ? u : d;
            v  = (s - t <= st) ? t : s - st;
        end
        return f_limit(v, cap);
    endfunction

    assign w_cap = (r_speed_cap > dmsr_pkg::FULL_SCALE) ? dmsr_pkg::FULL_SCALE : r_speed_cap;

    assign w_motion = (r_left_speed != '0) || (r_right_speed != '0) ||
                      (r_left_target != '0) || (r_right_target != '0);

    assign w_set_left  = f_limit(dmsr_pkg::WIDE_W'(i_left_target_in), w_cap);
    assign w_set_right = f_limit(dmsr_pkg::WIDE_W'(i_right_target_in), w_cap);

    // shared ramp unit
    assign w_ramp_spd = w_ramp_right ? r_right_speed  : r_left_speed;
    assign w_ramp_tgt = w_ramp_right ? r_right_target : r_left_target;
    assign w_ramp_new = f_ramp(w_ramp_spd, w_ramp_tgt, r_accel_step, r_decel_step, w_cap);

    // shared multiplier: period * (10000 + 9*|speed|), then times reciprocal
    assign w_mul_spd = w_mul_right ? r_right_speed : r_left_speed;
    always_comb begin
        logic signed [dmsr_pkg::SPEED_W-1:0] abs_v;
        abs_v = (w_mul_spd < 0) ? -w_mul_spd : w_mul_spd;
        w_mag = abs_v[dmsr_pkg::MAG_W-1:0];
    end
    assign w_base = dmsr_pkg::DUTY_OFFSET + {w_mag, 3'b000} + dmsr_pkg::BASE_W'(w_mag);
    assign w_op_a = w_mul_stage2 ? r_prod : dmsr_pkg::PROD_A_W'(r_pwm_period);
    assign w_op_b = w_mul_stage2 ? dmsr_pkg::RECIP : dmsr_pkg::PROD_B_W'(w_base);
    assign w_prod = dmsr_pkg::PROD_W'(w_op_a) * dmsr_pkg::PROD_W'(w_op_b);
    assign w_quot = w_prod[dmsr_pkg::RECIP_SHIFT +: dmsr_pkg::QUOT_W];

    always_comb begin
        if ({{(32-dmsr_pkg::QUOT_W){1'b0}}, w_quot} > DUTY_MAX) begin
            w_duty = DUTY_MAX[DUTY_WIDTH-1:0];
        end else begin
            w_duty = DUTY_WIDTH'(w_quot);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dmsr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_action == dmsr_pkg::ACT_TICK) ? dmsr_pkg::S_RAMP_L
                                                               : dmsr_pkg::S_DONE;
                end
            end
            dmsr_pkg::S_RAMP_L: n_state = dmsr_pkg::S_RAMP_R;
            dmsr_pkg::S_RAMP_R: n_state = dmsr_pkg::S_MUL_L;
            dmsr_pkg::S_MUL_L:  n_state = dmsr_pkg::S_DIV_L;
            dmsr_pkg::S_DIV_L:  n_state = dmsr_pkg::S_MUL_R;
            dmsr_pkg::S_MUL_R:  n_state = dmsr_pkg::S_DIV_R;
            dmsr_pkg::S_DIV_R:  n_state = dmsr_pkg::S_DONE;
            dmsr_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = dmsr_pkg::S_IDLE;
                end
            end
            default: n_state = dmsr_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready   = 1'b0;
        w_out_load   = 1'b0;
        w_ramp_right = 1'b0;
        w_mul_right  = 1'b0;
        w_mul_stage2 = 1'b0;
        case (r_state)
            dmsr_pkg::S_IDLE:   o_in_ready = 1'b1;
            dmsr_pkg::S_RAMP_R: w_ramp_right = 1'b1;
            dmsr_pkg::S_DIV_L:  w_mul_stage2 = 1'b1;
            dmsr_pkg::S_MUL_R:  w_mul_right = 1'b1;
            dmsr_pkg::S_DIV_R: begin
                w_mul_right  = 1'b1;
                w_mul_stage2 = 1'b1;
            end
            dmsr_pkg::S_DONE:   w_out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign w_in_take = o_in_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= dmsr_pkg::S_IDLE;
            r_speed_cap    <= dmsr_pkg::RST_SPEED_CAP;
            r_accel_step   <= dmsr_pkg::RST_ACCEL_STEP;
            r_decel_step   <= dmsr_pkg::RST_DECEL_STEP;
            r_pwm_period   <= dmsr_pkg::RST_PWM_PERIOD;
            r_left_target  <= '0;
            r_right_target <= '0;
            r_left_speed   <= '0;
            r_right_speed  <= '0;
            r_duty_lf      <= '0;
            r_duty_lr      <= '0;
            r_duty_rf      <= '0;
            r_duty_rr      <= '0;
            r_enable       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    dmsr_pkg::CFG_SPEED_CAP:  r_speed_cap  <= i_cfg_wdata;
                    dmsr_pkg::CFG_ACCEL_STEP: r_accel_step <= i_cfg_wdata;
                    dmsr_pkg::CFG_DECEL_STEP: r_decel_step <= i_cfg_wdata;
                    dmsr_pkg::CFG_PWM_PERIOD:
                        r_pwm_period <= i_cfg_wdata[dmsr_pkg::PERIOD_W-1:0];
                    default: ;
                endcase
            end

            if (w_in_take) begin
                case (i_action)
                    dmsr_pkg::ACT_SET: begin
                        r_left_target  <= w_set_left;
                        r_right_target <= w_set_right;
                    end
                    dmsr_pkg::ACT_STOP: begin
                        r_left_target  <= '0;
                        r_right_target <= '0;
                        r_left_speed   <= '0;
                        r_right_speed  <= '0;
                        r_duty_lf      <= '0;
                        r_duty_lr      <= '0;
                        r_duty_rf      <= '0;
                        r_duty_rr      <= '0;
                        r_enable       <= 1'b0;
                    end
                    default: ;
                endcase
            end

            case (r_state)
                dmsr_pkg::S_RAMP_L: r_left_speed  <= w_ramp_new;
                dmsr_pkg::S_RAMP_R: r_right_speed <= w_ramp_new;
                dmsr_pkg::S_DIV_L: begin
                    r_duty_lf <= (r_left_speed > 0) ? w_duty : '0;
                    r_duty_lr <= (r_left_speed < 0) ? w_duty : '0;
                end
                dmsr_pkg::S_DIV_R: begin
                    r_duty_rf <= (r_right_speed > 0) ? w_duty : '0;
                    r_duty_rr <= (r_right_speed < 0) ? w_duty : '0;
                    r_enable  <= w_motion;
                end
                default: ;
            endcase

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == dmsr_pkg::S_MUL_L || r_state == dmsr_pkg::S_MUL_R) begin
            r_prod <= w_prod[dmsr_pkg::PROD_A_W-1:0];
        end
        if (w_out_load) begin
            r_o_lf      <= r_duty_lf;
            r_o_lr      <= r_duty_lr;
            r_o_rf      <= r_duty_rf;
            r_o_rr      <= r_duty_rr;
            r_o_enable  <= r_enable;
            r_o_driving <= w_motion;
            r_o_lspd    <= r_left_speed;
            r_o_rspd    <= r_right_speed;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_left_forward_duty  = r_o_lf;
    assign o_left_reverse_duty  = r_o_lr;
    assign o_right_forward_duty = r_o_rf;
    assign o_right_reverse_duty = r_o_rr;
    assign o_bridge_enable      = r_o_enable;
    assign o_driving            = r_o_driving;
    assign o_left_speed_out     = r_o_lspd;
    assign o_right_speed_out    = r_o_rspd;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for dual_motor_speed_ramp_pwm: directed table, then random ramp traffic
// depends on dmsr_pkg and the dual_motor_speed_ramp_pwm rtl
module tb_top;

    localparam int         DUTY_W     = 10;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         DUTY_TOP   = (1 << DUTY_W) - 1;
    localparam int         HOLD_PHASE = 4;
    localparam int         PAUSE_PHASE = 5;
    localparam int         NUM_PHASES = 8;
    localparam int         NUM_ROWS   = 24;

    typedef struct packed {
        logic [DUTY_W-1:0]                   lf;
        logic [DUTY_W-1:0]                   lr;
        logic [DUTY_W-1:0]                   rf;
        logic [DUTY_W-1:0]                   rr;
        logic                                en;
        logic                                drv;
        logic signed [dmsr_pkg::SPEED_W-1:0] ls;
        logic signed [dmsr_pkg::SPEED_W-1:0] rs;
    } t_drive_out;

    typedef struct packed {
        logic [1:0]                           act;
        logic signed [dmsr_pkg::TARGET_W-1:0] lt;
        logic signed [dmsr_pkg::TARGET_W-1:0] rt;
        logic                                 typed;
        t_drive_out                           want;
    } t_dir_row;

    // cap, accel, decel, period (negative picks a random value), idle %, stall %, beats
    typedef struct {
        int cap;
        int accel;
        int decel;
        int period;
        int send_idle;
        int recv_stall;
        int beats;
    } t_phase;

    localparam t_drive_out REST_OUT  = '0;
    // targets stored, nothing moved yet
    localparam t_drive_out ARMED_OUT = '{lf: '0, lr: '0, rf: '0, rr: '0, en: 1'b0,
                                         drv: 1'b1, ls: '0, rs: '0};

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic [1:0]                           i_action;
    logic signed [dmsr_pkg::TARGET_W-1:0] i_left_target_in;
    logic signed [dmsr_pkg::TARGET_W-1:0] i_right_target_in;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    logic [DUTY_W-1:0]                    o_left_forward_duty;
    logic [DUTY_W-1:0]                    o_left_reverse_duty;
    logic [DUTY_W-1:0]                    o_right_forward_duty;
    logic [DUTY_W-1:0]                    o_right_reverse_duty;
    logic                                 o_bridge_enable;
    logic                                 o_driving;
    logic signed [dmsr_pkg::SPEED_W-1:0]  o_left_speed_out;
    logic signed [dmsr_pkg::SPEED_W-1:0]  o_right_speed_out;
    logic                                 i_cfg_wr_en;
    logic [dmsr_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [dmsr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata;

    dual_motor_speed_ramp_pwm #(
        .DUTY_WIDTH(DUTY_W)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_left_target_in    (i_left_target_in),
        .i_right_target_in   (i_right_target_in),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_left_forward_duty (o_left_forward_duty),
        .o_left_reverse_duty (o_left_reverse_duty),
        .o_right_forward_duty(o_right_forward_duty),
        .o_right_reverse_duty(o_right_reverse_duty),
        .o_bridge_enable     (o_bridge_enable),
        .o_driving           (o_driving),
        .o_left_speed_out    (o_left_speed_out),
        .o_right_speed_out   (o_right_speed_out),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata)
    );

    // predicted copy of the block's registers and state
    logic [dmsr_pkg::STEP_W-1:0]         cap_m;
    logic [dmsr_pkg::STEP_W-1:0]         accel_m;
    logic [dmsr_pkg::STEP_W-1:0]         decel_m;
    logic [dmsr_pkg::PERIOD_W-1:0]       period_m;
    logic signed [dmsr_pkg::SPEED_W-1:0] l_tgt_m;
    logic signed [dmsr_pkg::SPEED_W-1:0] r_tgt_m;
    logic signed [dmsr_pkg::SPEED_W-1:0] l_spd_m;
    logic signed [dmsr_pkg::SPEED_W-1:0] r_spd_m;
    logic [DUTY_W-1:0]                   duty_m [4];
    logic                                enable_m;

    t_drive_out drive_out_q [$];
    int         errors = 0;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_left;
    int         hold_requests = 0;
    int         hold_served;

    t_dir_row dir_rows [NUM_ROWS] = '{
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b1, REST_OUT},
        '{dmsr_pkg::ACT_SET,   16'sh7fff,   16'sh8000,   1'b1, ARMED_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b0, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sh5a5a,   16'sha5a5,   1'b0, REST_OUT},
        '{dmsr_pkg::ACT_SET,   -16'sd100,   16'sd100,    1'b0, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b0, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b0, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b0, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b0, REST_OUT},
        '{ACT_UNUSED,          16'sh7fff,   16'sh8000,   1'b0, REST_OUT},
        '{dmsr_pkg::ACT_SET,   16'sd0,      16'sd0,      1'b0, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b0, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b0, REST_OUT},
        '{dmsr_pkg::ACT_STOP,  16'sh7fff,   16'sh7fff,   1'b1, REST_OUT},
        '{dmsr_pkg::ACT_SET,   16'sd1,      -16'sd1,     1'b0, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b0, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b0, REST_OUT},
        '{dmsr_pkg::ACT_SET,   16'sh8000,   16'sh7fff,   1'b0, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b0, REST_OUT},
        '{dmsr_pkg::ACT_STOP,  16'sh8000,   16'sh8000,   1'b1, REST_OUT},
        '{dmsr_pkg::ACT_SET,   16'sd0,      16'sd0,      1'b1, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'shffff,   16'shffff,   1'b1, REST_OUT},
        '{dmsr_pkg::ACT_SET,   16'sd10000,  -16'sd10000, 1'b0, REST_OUT},
        '{dmsr_pkg::ACT_TICK,  16'sd0,      16'sd0,      1'b0, REST_OUT}
    };

    t_phase phases [NUM_PHASES] = '{
        '{10000, 30,    10,    799,  0,  0,  150},
        '{16383, 10000, 10000, 1023, 79, 0,  120},
        '{0,     0,     0,     0,    0,  79, 60},
        '{5000,  500,   200,   1,    16, 16, 150},
        '{2000,  1,     3,     512,  0,  0,  150},
        '{10000, 16383, 0,     799,  0,  79, 120},
        '{12000, 250,   250,   1023, 79, 0,  150},
        '{-1,    -1,    -1,    -1,   16, 16, 100}
    };

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    function automatic int cap_limit();
        return (cap_m > dmsr_pkg::FULL_SCALE) ? int'(dmsr_pkg::FULL_SCALE) : int'(cap_m);
    endfunction

    function automatic int clamp_speed(int v, int c);
        if (v < -c) return -c;
        if (v > c) return c;
        return v;
    endfunction

    // one tick of the slew limiter; a reversal stops at zero first
    function automatic int ramp_speed(int spd, int tgt);
        int up;
        int dn;
        int st;
        int nxt;
        up = int'(accel_m);
        dn = int'(decel_m);
        if (spd == tgt) return spd;
        if (spd > 0 && tgt < 0) begin
            nxt = (spd <= dn) ? 0 : spd - dn;
        end else if (spd < 0 && tgt > 0) begin
            nxt = (-spd <= dn) ? 0 : spd + dn;
        end else if (tgt > spd) begin
            st  = (spd >= 0) ? up : dn;
            nxt = (tgt - spd <= st) ? tgt : spd + st;
        end else begin
            st  = (spd <= 0) ? up : dn;
            nxt = (spd - tgt <= st) ? tgt : spd - st;
        end
        return clamp_speed(nxt, cap_limit());
    endfunction

    function automatic logic [DUTY_W-1:0] duty_for(int spd);
        longint mag;
        longint d;
        mag = (spd < 0) ? -spd : spd;
        d   = longint'(period_m) * (64'sd10000 + 64'sd9 * mag) / 64'sd100000;
        if (d > DUTY_TOP) d = DUTY_TOP;
        return d[DUTY_W-1:0];
    endfunction

    function automatic logic any_motion();
        return (l_spd_m != 0) || (r_spd_m != 0) || (l_tgt_m != 0) || (r_tgt_m != 0);
    endfunction

    // advances the predicted state by one beat and returns the result it causes
    function automatic t_drive_out apply_command(logic [1:0] act,
                                                 logic signed [dmsr_pkg::TARGET_W-1:0] lt,
                                                 logic signed [dmsr_pkg::TARGET_W-1:0] rt);
        t_drive_out r;
        int         ls;
        int         rs;
        case (act)
            dmsr_pkg::ACT_SET: begin
                l_tgt_m = dmsr_pkg::SPEED_W'(clamp_speed(int'(lt), cap_limit()));
                r_tgt_m = dmsr_pkg::SPEED_W'(clamp_speed(int'(rt), cap_limit()));
            end
            dmsr_pkg::ACT_TICK: begin
                ls        = ramp_speed(int'(l_spd_m), int'(l_tgt_m));
                rs        = ramp_speed(int'(r_spd_m), int'(r_tgt_m));
                l_spd_m   = dmsr_pkg::SPEED_W'(ls);
                r_spd_m   = dmsr_pkg::SPEED_W'(rs);
                duty_m[0] = (ls > 0) ? duty_for(ls) : '0;
                duty_m[1] = (ls < 0) ? duty_for(ls) : '0;
                duty_m[2] = (rs > 0) ? duty_for(rs) : '0;
                duty_m[3] = (rs < 0) ? duty_for(rs) : '0;
                enable_m  = any_motion();
            end
            dmsr_pkg::ACT_STOP: begin
                l_tgt_m  = '0;
                r_tgt_m  = '0;
                l_spd_m  = '0;
                r_spd_m  = '0;
                duty_m   = '{default: '0};
                enable_m = 1'b0;
            end
            default: ;
        endcase
        r.lf  = duty_m[0];
        r.lr  = duty_m[1];
        r.rf  = duty_m[2];
        r.rr  = duty_m[3];
        r.en  = enable_m;
        r.drv = any_motion();
        r.ls  = l_spd_m;
        r.rs  = r_spd_m;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // result side: compare every accepted beat with the oldest prediction
    always @(posedge i_clk) begin
        t_drive_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (drive_out_q.size() == 0) begin
                $display("%0t: result beat with nothing expected", $time);
                errors++;
            end else begin
                want = drive_out_q.pop_front();
                check_field("left_forward_duty", int'(want.lf), int'(o_left_forward_duty));
                check_field("left_reverse_duty", int'(want.lr), int'(o_left_reverse_duty));
                check_field("right_forward_duty", int'(want.rf),
                            int'(o_right_forward_duty));
                check_field("right_reverse_duty", int'(want.rr),
                            int'(o_right_reverse_duty));
                check_field("bridge_enable", int'(want.en), int'(o_bridge_enable));
                check_field("driving", int'(want.drv), int'(o_driving));
                check_field("left_speed_out", int'(want.ls), int'(o_left_speed_out));
                check_field("right_speed_out", int'(want.rs), int'(o_right_speed_out));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        hold_left   = 0;
        hold_served = 0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_served) begin
                hold_left   = 400;
                hold_served = hold_requests;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_beat(input logic [1:0] act,
                              input logic signed [dmsr_pkg::TARGET_W-1:0] lt,
                              input logic signed [dmsr_pkg::TARGET_W-1:0] rt,
                              input logic typed, input t_drive_out want);
        t_drive_out predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_action          <= act;
        i_left_target_in  <= lt;
        i_right_target_in <= rt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = apply_command(act, lt, rt);
        drive_out_q.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic offer_random();
        logic [1:0]                           act;
        logic signed [dmsr_pkg::TARGET_W-1:0] lt;
        logic signed [dmsr_pkg::TARGET_W-1:0] rt;
        int                                   pick;
        int                                   c;
        pick = $urandom_range(99);
        c    = cap_limit();
        lt   = dmsr_pkg::TARGET_W'($urandom);
        rt   = dmsr_pkg::TARGET_W'($urandom);
        if (pick < 65) begin
            act = dmsr_pkg::ACT_TICK;
        end else if (pick < 93) begin
            act = dmsr_pkg::ACT_SET;
            // mostly reachable targets, sometimes anything the field holds
            if ($urandom_range(3) != 0) begin
                lt = dmsr_pkg::TARGET_W'(int'($urandom_range(2 * c)) - c);
                rt = dmsr_pkg::TARGET_W'(int'($urandom_range(2 * c)) - c);
            end
        end else if (pick < 96) begin
            act = dmsr_pkg::ACT_STOP;
        end else begin
            act = ACT_UNUSED;
        end
        offer_beat(act, lt, rt, 1'b0, REST_OUT);
    endtask

    task automatic drain_results();
        while (drive_out_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input dmsr_pkg::t_cfg_index idx, input int value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= dmsr_pkg::CFG_DATA_W'(value);
        @(negedge i_clk);
        case (idx)
            dmsr_pkg::CFG_SPEED_CAP:  cap_m    = dmsr_pkg::STEP_W'(value);
            dmsr_pkg::CFG_ACCEL_STEP: accel_m  = dmsr_pkg::STEP_W'(value);
            dmsr_pkg::CFG_DECEL_STEP: decel_m  = dmsr_pkg::STEP_W'(value);
            dmsr_pkg::CFG_PWM_PERIOD: period_m = dmsr_pkg::PERIOD_W'(value);
            default: ;
        endcase
    endtask

    function automatic int pick_value(int v, int hi);
        return (v < 0) ? int'($urandom_range(hi)) : v;
    endfunction

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_action          = dmsr_pkg::ACT_SET;
        i_left_target_in  = '0;
        i_right_target_in = '0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_index       = dmsr_pkg::CFG_SPEED_CAP;
        i_cfg_wdata       = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        cap_m             = dmsr_pkg::RST_SPEED_CAP;
        accel_m           = dmsr_pkg::RST_ACCEL_STEP;
        decel_m           = dmsr_pkg::RST_DECEL_STEP;
        period_m          = dmsr_pkg::RST_PWM_PERIOD;
        l_tgt_m           = '0;
        r_tgt_m           = '0;
        l_spd_m           = '0;
        r_spd_m           = '0;
        duty_m            = '{default: '0};
        enable_m          = 1'b0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[n]) begin
            offer_beat(dir_rows[n].act, dir_rows[n].lt, dir_rows[n].rt,
                       dir_rows[n].typed, dir_rows[n].want);
        end

        for (int k = 0; k < NUM_PHASES; k++) begin
            i_in_valid <= 1'b0;
            drain_results();
            // registers change only with the pipeline empty
            write_reg(dmsr_pkg::CFG_SPEED_CAP, pick_value(phases[k].cap, 16383));
            write_reg(dmsr_pkg::CFG_ACCEL_STEP, pick_value(phases[k].accel, 16383));
            write_reg(dmsr_pkg::CFG_DECEL_STEP, pick_value(phases[k].decel, 16383));
            write_reg(dmsr_pkg::CFG_PWM_PERIOD, pick_value(phases[k].period, 1023));
            i_cfg_wr_en    <= 1'b0;
            send_idle_pct  = phases[k].send_idle;
            recv_stall_pct = phases[k].recv_stall;
            for (int n = 0; n < phases[k].beats; n++) begin
                if (k == HOLD_PHASE && n == 0) hold_requests++;
                if (k == PAUSE_PHASE && n == phases[k].beats / 2) begin
                    i_in_valid <= 1'b0;
                    drain_results();
                end
                offer_random();
            end
        end

        i_in_valid <= 1'b0;
        drain_results();
        // a stray beat in this window still counts as an error
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
